### hdl/csd_pkg.sv
// Shared types and constants for the console stream demultiplexer.
// Holds the transaction structs, the result kind codes and the command format.
// No dependencies.
`timescale 1ns / 1ps

package csd_pkg;

  // Most data bytes that a single input byte can produce (five held UTF-8 bytes plus one)
  localparam int MAX_DATA  = 6;
  // Width of a per-command result count (data bytes plus the end marker)
  localparam int CNT_W     = $clog2(MAX_DATA + 2);
  // Default depth of the command queue between parser and expander
  localparam int CMD_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_TEXT  = 2'd0,
    KIND_FRAME = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // One parsed input byte: n_data bytes of data_kind, optionally followed by an end marker
  typedef struct packed {
    kind_e                      data_kind;
    logic                       has_end;
    logic [CNT_W-1:0]           n_data;
    logic [MAX_DATA-1:0][7:0]   data;
  } cmd_t;

endpackage

### hdl/console_stream_demux.sv
// Top level of the console stream demultiplexer.
// Instantiates csd_front, csd_cmd_fifo and csd_back; depends on csd_pkg.
//
// Usage:
//   Input queue side: drive in_item_i and raise push; the byte is taken at a
//   clock edge where push is high and full is low. One byte per cycle is
//   accepted as long as the command queue has room.
//   Result queue side: while empty is low, out_item_o holds the oldest result;
//   raise pop to take it. A result transaction leaves every cycle while the
//   consumer keeps popping and commands are queued.
//   A byte is parsed into the command queue at the edge that accepts it; its
//   results are then expanded into the output register once the queue holds
//   no older command and the register is free or popped. A byte yields zero
//   to six results; the expander emits one per cycle while the output is
//   popped, and a byte with no results queues no command.
//   Sustained rate is one byte per cycle for plain text, set by the expander, while popped.
//   Stall: when pop stays low the output register holds, the command queue
//   (CmdDepth entries) fills, and full rises; no data is dropped.
//   Reset: parser returns to plain text mode, frame group and queues empty.
`timescale 1ns / 1ps

module console_stream_demux #(
  parameter int CmdDepth = csd_pkg::CMD_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  csd_pkg::in_item_t  in_item_i,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output csd_pkg::out_item_t out_item_o
);
  import csd_pkg::*;

  logic  cmd_valid;
  cmd_t  cmd_wr;
  cmd_t  cmd_head;
  logic  cmd_full;
  logic  cmd_empty;
  logic  cmd_pop;
  logic  out_valid;

  assign full  = cmd_full;
  assign empty = !out_valid;

  csd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push && !cmd_full),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_wr)
  );

  csd_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_valid),
    .wr_data_i (cmd_wr),
    .rd_en_i   (cmd_pop),
    .rd_data_o (cmd_head),
    .full_o    (cmd_full),
    .empty_o   (cmd_empty)
  );

  csd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .out_item_o  (out_item_o)
  );

endmodule

### hdl/csd_front.sv
// Front end: parses raw console bytes and turns each into at most one queued command.
// Holds the parser mode, the UTF-8 hold buffer and the 18-bit accumulator of 6-bit frame characters.
// Depends on csd_pkg.
`timescale 1ns / 1ps

module csd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  csd_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  output csd_pkg::cmd_t     cmd_o
);
  import csd_pkg::*;

  localparam int UTF8_DEPTH = 5;

  // Parser modes
  localparam logic [1:0] MODE_ASCII = 2'd0;
  localparam logic [1:0] MODE_UTF8  = 2'd1;
  localparam logic [1:0] MODE_ESC0  = 2'd2;
  localparam logic [1:0] MODE_ESC1  = 2'd3;

  localparam logic [7:0] BYTE_ESC   = 8'hFF;
  localparam logic [7:0] BYTE_FLUSH = 8'hFE;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;

  logic [1:0]  mode_q, mode_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [17:0] acc_q, acc_d;
  logic [1:0]  pos_q, pos_d;
  logic [7:0]  store_q [UTF8_DEPTH];

  logic        store_we;
  logic [2:0]  store_idx;

  logic [7:0]  b;
  logic [1:0]  m;
  logic [2:0]  c;
  logic [17:0] a;
  logic [1:0]  p;
  logic [5:0]  ch;
  logic [23:0] grp;
  logic [2:0]  need_b;
  logic [2:0]  need_s;

  // Continuation bytes a lead byte calls for; zero when it is no lead byte
  function automatic logic [2:0] lead_need(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    if      (v[7:5] == 3'b110)    r = 3'd1;
    else if (v[7:4] == 4'b1110)   r = 3'd2;
    else if (v[7:3] == 5'b11110)  r = 3'd3;
    else if (v[7:2] == 6'b111110) r = 3'd4;
    else if (v[7:1] == 7'b1111110) r = 3'd5;
    return r;
  endfunction

  assign b      = in_item_i.in_byte;
  assign ch     = b[5:0];
  assign need_b = lead_need(b);
  assign need_s = lead_need(store_q[0]);

  // Parse one byte: next state and the command it produces
  always_comb begin
    mode_d    = mode_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    pos_d     = pos_q;
    store_we  = 1'b0;
    store_idx = 3'd0;
    cmd_valid_o     = 1'b0;
    cmd_o.data_kind = KIND_TEXT;
    cmd_o.has_end   = 1'b0;
    cmd_o.n_data    = '0;
    cmd_o.data      = '0;

    // restart clears everything before the byte is looked at
    m = in_item_i.restart ? MODE_ASCII : mode_q;
    c = in_item_i.restart ? 3'd0 : cnt_q;
    a = in_item_i.restart ? 18'd0 : acc_q;
    p = in_item_i.restart ? 2'd0 : pos_q;
    grp = {ch, a};

    // broken sequence or escape without zero: fall back to plain handling
    if (m == MODE_UTF8 && b[7:6] != 2'b10) m = MODE_ASCII;
    if (m == MODE_ESC0 && b != BYTE_ZERO)  m = MODE_ASCII;

    if (in_valid_i) begin
      mode_d = m;
      cnt_d  = c;
      acc_d  = a;
      pos_d  = p;
      unique case (m)
        MODE_ASCII: begin
          priority if (need_b != 3'd0) begin
            store_we  = 1'b1;
            store_idx = 3'd0;
            cnt_d     = 3'd1;
            mode_d    = MODE_UTF8;
          end else if (b == BYTE_ESC) begin
            mode_d = MODE_ESC0;
          end else if (b[7:6] == 2'b10) begin
            // frame character
            if (p == 2'd3) begin
              cmd_valid_o     = 1'b1;
              cmd_o.data_kind = KIND_FRAME;
              cmd_o.n_data    = CNT_W'(3);
              cmd_o.data[0]   = grp[7:0];
              cmd_o.data[1]   = grp[15:8];
              cmd_o.data[2]   = grp[23:16];
              acc_d = 18'd0;
              pos_d = 2'd0;
            end else begin
              unique case (p)
                2'd0:    acc_d = a | {12'd0, ch};
                2'd1:    acc_d = a | {6'd0, ch, 6'd0};
                2'd2:    acc_d = a | {ch, 12'd0};
                default: acc_d = a;
              endcase
              pos_d = p + 2'd1;
            end
          end else if (b == BYTE_FLUSH) begin
            // flush partial group, then frame end
            cmd_valid_o     = 1'b1;
            cmd_o.data_kind = KIND_FRAME;
            cmd_o.has_end   = 1'b1;
            cmd_o.data[0]   = a[7:0];
            cmd_o.data[1]   = a[15:8];
            if (p == 2'd3)      cmd_o.n_data = CNT_W'(2);
            else if (p == 2'd2) cmd_o.n_data = CNT_W'(1);
            acc_d = 18'd0;
            pos_d = 2'd0;
          end else if (!b[7]) begin
            cmd_valid_o     = 1'b1;
            cmd_o.n_data    = CNT_W'(1);
            cmd_o.data[0]   = b;
          end
        end
        MODE_UTF8: begin
          if (c == need_s) begin
            // sequence complete: held bytes then this one
            cmd_valid_o  = 1'b1;
            cmd_o.n_data = CNT_W'(c) + CNT_W'(1);
            for (int i = 0; i < MAX_DATA; i++) begin
              if (i < UTF8_DEPTH && 3'(i) != c) cmd_o.data[i] = store_q[i];
              else                              cmd_o.data[i] = b;
            end
            cnt_d  = 3'd0;
            mode_d = MODE_ASCII;
          end else if (c < 3'(UTF8_DEPTH)) begin
            store_we  = 1'b1;
            store_idx = c;
            cnt_d     = c + 3'd1;
          end else begin
            cnt_d  = 3'd0;
            mode_d = MODE_ASCII;
          end
        end
        MODE_ESC0: mode_d = MODE_ESC1;
        MODE_ESC1: mode_d = MODE_ASCII;
      endcase
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ASCII;
      cnt_q  <= 3'd0;
      acc_q  <= 18'd0;
      pos_q  <= 2'd0;
    end else begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
      pos_q  <= pos_d;
    end
  end

  // UTF-8 hold buffer; only entries below the fill count reach the output
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < UTF8_DEPTH; i++) begin
      if (store_we && store_idx == 3'(i)) store_q[i] <= b;
    end
  end

endmodule

### hdl/csd_cmd_fifo.sv
// Short command queue between the parser and the result expander.
// Register-based circular buffer with occupancy count.
// Depends on csd_pkg.
`timescale 1ns / 1ps

module csd_cmd_fifo #(
  parameter int Depth = csd_pkg::CMD_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  csd_pkg::cmd_t wr_data_i,
  input  logic          rd_en_i,
  output csd_pkg::cmd_t rd_data_o,
  output logic          full_o,
  output logic          empty_o
);
  import csd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd)      count_q <= count_q + CntW'(1);
      else if (!do_wr && do_rd) count_q <= count_q - CntW'(1);
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

### hdl/csd_back.sv
// Back end: expands queued commands into result transactions, one per cycle
// while its output register is free or popped. It ends in that register,
// which the consumer drains with pop. Depends on csd_pkg.
`timescale 1ns / 1ps

module csd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_empty_i,
  input  csd_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  input  logic               pop_i,
  output logic               out_valid_o,
  output csd_pkg::out_item_t out_item_o
);
  import csd_pkg::*;

  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] total;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;
  logic             advance;
  logic             at_last;
  logic [7:0]       sel_byte;

  assign total   = cmd_i.n_data + CNT_W'(cmd_i.has_end);
  assign at_last = (idx_q == total - CNT_W'(1));
  assign advance = !cmd_empty_i && (!out_valid_q || pop_i);

  // Pick the data byte at the current position
  always_comb begin
    sel_byte = 8'd0;
    for (int i = 0; i < MAX_DATA; i++) begin
      if (idx_q == CNT_W'(i)) sel_byte = cmd_i.data[i];
    end
  end

  // Next result and position within the command
  always_comb begin
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    cmd_pop_o   = 1'b0;
    if (advance) begin
      out_valid_d = 1'b1;
      if (idx_q < cmd_i.n_data) begin
        out_d.kind     = cmd_i.data_kind;
        out_d.out_byte = sel_byte;
      end else begin
        out_d.kind     = KIND_END;
        out_d.out_byte = 8'd0;
      end
      out_d.last = at_last;
      if (at_last) begin
        idx_d     = '0;
        cmd_pop_o = 1'b1;
      end else begin
        idx_d = idx_q + CNT_W'(1);
      end
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
